### hw/rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg: shared constants and types of the projected screen box
// Fixed-point formats, datapath widths, register and point codes, and the
// structures that pass between the pipeline sections.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int CFB       = 4;
  localparam int MFB       = 16;
  localparam int POS_W     = 32;
  localparam int EXT_W     = 24;
  localparam int MAT_W     = 32;
  localparam int VIEW_W    = 14;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_MAT   = 6;
  localparam int SCR_W     = 20;
  localparam int BOX_W     = 19;
  localparam int NPT       = 5;
  localparam int NCH       = 3;

  localparam int PROD_W  = MAT_W + POS_W;
  localparam int DELTA_W = MAT_W + EXT_W + 1;
  localparam int CLIP_W  = PROD_W + 4;
  localparam int A_W     = CLIP_W + 1;
  localparam int LO_W    = A_W / 2;
  localparam int HI_W    = A_W - LO_W;
  localparam int K_W     = VIEW_W + CFB;
  localparam int PH_W    = HI_W + K_W + 1;
  localparam int PL_W    = LO_W + K_W;
  localparam int NUM_W   = PH_W + LO_W + 2;
  localparam int DEN_W   = CLIP_W + 1;
  localparam int DIV_W   = NUM_W + 2;

  localparam longint THRESH = (64'd1 << (MFB + CFB)) / 64'd1000000;

  localparam int CLIP_STAGES = 7;
  localparam int DIV_STAGES  = SCR_W + 1;
  localparam int BOX_STAGES  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_XY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ZT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_W  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_H  = 3'd7;

  localparam int CH_X = 0;
  localparam int CH_Y = 1;
  localparam int CH_W = 2;

  localparam int PT_CENTRE = 0;
  localparam int PT_TOP    = 1;
  localparam int PT_BOTTOM = 2;
  localparam int PT_LEFT   = 3;
  localparam int PT_RIGHT  = 4;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic [DEN_W-1:0]        den;
    logic                    bad;
  } psb_pt_t;

  typedef struct packed {
    logic                    ok;
    logic signed [SCR_W-1:0] q;
  } psb_quo_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [SCR_W-1:0] center_x;
    logic signed [SCR_W-1:0] center_y;
    logic [BOX_W-1:0]        box_w;
    logic [BOX_W-1:0]        box_h;
  } psb_res_t;

endpackage

### hw/rtl/projected_screen_box.sv
// ----------------------------------------------------------------------------
// projected_screen_box: screen-space box of a world object
// Projects an object's centre and four extent points through a fixed-point
// view-projection matrix and returns its screen centre and box size.
// ----------------------------------------------------------------------------
// Matrix and viewport are written over the cfg channel (index and 64-bit
// data); the user must write them only while the block is idle, which the
// block itself does not enforce. cfg_ready_o is always high. Each beat on
// the slave stream carries one object; each beat on the master stream
// carries one result, with valid_res on tuser. An object may be accepted
// in every cycle while tready is high. 7 stages build the clip values and
// numerators, 21 division stages check the range and then resolve the
// quotient one bit per stage, and 2 stages form and clamp the box.
// The pipeline advances as a whole; a two-entry output queue sits behind it,
// so the slave side stays ready while one result waits. When the receiver
// stalls long enough to fill the queue, the pipeline holds and tready falls.
// Reset empties the pipeline and queue, clears the matrix and sets the
// viewport to 1920 by 1080 pixels.
// ----------------------------------------------------------------------------
module projected_screen_box import psb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pos_x, pos_y, pos_z, radius, half_height
  input  logic [143:0]         s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // center_x, center_y, box_w, box_h, two zero bits
  output logic [79:0]          m_axis_tdata,
  // valid_res
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int NS       = CLIP_STAGES + DIV_STAGES + BOX_STAGES;
  localparam int OQ_DEPTH = 2;
  localparam int PTR_W    = $clog2(OQ_DEPTH);
  localparam int CNT_W    = $clog2(OQ_DEPTH + 1);

  logic [NUM_MAT-1:0][CFG_W-1:0] mat_q;
  logic [VIEW_W-1:0]             vw_q, vh_q;

  logic                          adv, push, pop;
  logic [NS-1:0]                 v_q;
  psb_pt_t [NPT-1:0]             pt;
  psb_quo_t [NPT-1:0]            quo_x, quo_y;
  psb_res_t                      res;

  psb_res_t                      oq_q [OQ_DEPTH];
  logic [PTR_W-1:0]              wr_q, rd_q;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  psb_res_t                      head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
      vw_q  <= VIEW_W'(1920);
      vh_q  <= VIEW_W'(1080);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z, REG_ROW_T, REG_CLIP_XY, REG_CLIP_ZT: begin
          mat_q[cfg_index_i] <= cfg_data_i;
        end
        REG_VIEW_W: begin
          vw_q <= cfg_data_i[VIEW_W-1:0];
        end
        REG_VIEW_H: begin
          vh_q <= cfg_data_i[VIEW_W-1:0];
        end
      endcase
    end
  end

  assign adv           = (cnt_q != CNT_W'(OQ_DEPTH));
  assign s_axis_tready = adv;
  assign push          = adv & v_q[NS-1];
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], s_axis_tvalid};
    end
  end

  psb_clip u_clip (
    .clk_i         (clk_i),
    .en_i          (adv),
    .mat_i         (mat_q),
    .view_w_i      (vw_q),
    .view_h_i      (vh_q),
    .pos_x_i       (s_axis_tdata[31:0]),
    .pos_y_i       (s_axis_tdata[63:32]),
    .pos_z_i       (s_axis_tdata[95:64]),
    .radius_i      (s_axis_tdata[119:96]),
    .half_height_i (s_axis_tdata[143:120]),
    .pt_o          (pt)
  );

  for (genvar k = 0; k < NPT; k++) begin : g_div
    psb_div u_div_x (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (pt[k].num_x),
      .den_i (pt[k].den),
      .ok_i  (~pt[k].bad),
      .quo_o (quo_x[k])
    );
    psb_div u_div_y (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (pt[k].num_y),
      .den_i (pt[k].den),
      .ok_i  (~pt[k].bad),
      .quo_o (quo_y[k])
    );
  end

  psb_box u_box (
    .clk_i    (clk_i),
    .en_i     (adv),
    .quo_x_i  (quo_x),
    .quo_y_i  (quo_y),
    .view_w_i (vw_q),
    .view_h_i (vh_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[wr_q] <= res;
    end
  end

  assign cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign head          = oq_q[rd_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.valid_res;
  assign m_axis_tdata  = {2'b00, head.box_h, head.box_w, head.center_y, head.center_x};

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OQ_DEPTH))
    else $error("output queue count beyond its depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("result written to the queue but not offered");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

### hw/rtl/psb_clip.sv
// ----------------------------------------------------------------------------
// psb_clip: clip-space front end
// Registers the object, forms the clip coordinates of the five points and
// the numerators and denominator of each fused divide and viewport map.
// ----------------------------------------------------------------------------
module psb_clip import psb_pkg::*; (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [NUM_MAT-1:0][CFG_W-1:0]   mat_i,
  input  logic [VIEW_W-1:0]               view_w_i,
  input  logic [VIEW_W-1:0]               view_h_i,
  input  logic signed [POS_W-1:0]         pos_x_i,
  input  logic signed [POS_W-1:0]         pos_y_i,
  input  logic signed [POS_W-1:0]         pos_z_i,
  input  logic [EXT_W-1:0]                radius_i,
  input  logic [EXT_W-1:0]                half_height_i,
  output psb_pt_t [NPT-1:0]               pt_o
);

  logic signed [MAT_W-1:0]   cm_x [NCH];
  logic signed [MAT_W-1:0]   cm_y [NCH];
  logic signed [MAT_W-1:0]   cm_z [NCH];
  logic signed [MAT_W-1:0]   cm_t [NCH];
  logic signed [CLIP_W-1:0]  t_ext [NCH];
  logic signed [CLIP_W-1:0]  thr;

  logic signed [POS_W-1:0]   px_q, py_q, pz_q;
  logic [EXT_W-1:0]          rad_q, hh_q;
  logic signed [EXT_W:0]     rad_s, hh_s;

  logic signed [PROD_W-1:0]  prx_q [NCH];
  logic signed [PROD_W-1:0]  pry_q [NCH];
  logic signed [PROD_W-1:0]  prz_q [NCH];
  logic signed [DELTA_W-1:0] dz_q [NCH];
  logic signed [DELTA_W-1:0] dx_q [NCH];

  logic signed [CLIP_W-1:0]  base_q [NCH];
  logic signed [DELTA_W-1:0] dz2_q [NCH];
  logic signed [DELTA_W-1:0] dx2_q [NCH];

  logic signed [CLIP_W-1:0]  pv_q [NPT][NCH];

  logic signed [A_W-1:0]     a_q [NPT];
  logic signed [A_W-1:0]     b_q [NPT];
  logic signed [CLIP_W-1:0]  cw4_q [NPT];
  logic                      bad4_q [NPT];

  logic [K_W-1:0]            kx, ky;
  logic signed [K_W:0]       kx_s, ky_s;
  logic signed [PH_W-1:0]    phx_q [NPT];
  logic signed [PH_W-1:0]    phy_q [NPT];
  logic [PL_W-1:0]           plx_q [NPT];
  logic [PL_W-1:0]           ply_q [NPT];
  logic signed [CLIP_W-1:0]  cw5_q [NPT];
  logic                      bad5_q [NPT];

  logic signed [NUM_W-1:0]   hx_e [NPT];
  logic signed [NUM_W-1:0]   hy_e [NPT];
  logic signed [NUM_W-1:0]   lx_e [NPT];
  logic signed [NUM_W-1:0]   ly_e [NPT];
  logic signed [NUM_W-1:0]   w_e [NPT];
  psb_pt_t [NPT-1:0]         pt_d, pt_q;

  always_comb begin
    cm_x[CH_X] = mat_i[REG_ROW_X][MAT_W-1:0];
    cm_x[CH_Y] = mat_i[REG_ROW_X][CFG_W-1:MAT_W];
    cm_x[CH_W] = mat_i[REG_CLIP_XY][MAT_W-1:0];
    cm_y[CH_X] = mat_i[REG_ROW_Y][MAT_W-1:0];
    cm_y[CH_Y] = mat_i[REG_ROW_Y][CFG_W-1:MAT_W];
    cm_y[CH_W] = mat_i[REG_CLIP_XY][CFG_W-1:MAT_W];
    cm_z[CH_X] = mat_i[REG_ROW_Z][MAT_W-1:0];
    cm_z[CH_Y] = mat_i[REG_ROW_Z][CFG_W-1:MAT_W];
    cm_z[CH_W] = mat_i[REG_CLIP_ZT][MAT_W-1:0];
    cm_t[CH_X] = mat_i[REG_ROW_T][MAT_W-1:0];
    cm_t[CH_Y] = mat_i[REG_ROW_T][CFG_W-1:MAT_W];
    cm_t[CH_W] = mat_i[REG_CLIP_ZT][CFG_W-1:MAT_W];
    for (int c = 0; c < NCH; c++) begin
      t_ext[c] = cm_t[c];
      t_ext[c] = t_ext[c] <<< CFB;
    end
  end

  assign thr   = $signed(CLIP_W'(THRESH));
  assign rad_s = $signed({1'b0, rad_q});
  assign hh_s  = $signed({1'b0, hh_q});
  assign kx    = K_W'(view_w_i) << CFB;
  assign ky    = K_W'(view_h_i) << CFB;
  assign kx_s  = $signed({1'b0, kx});
  assign ky_s  = $signed({1'b0, ky});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
      rad_q <= radius_i;
      hh_q  <= half_height_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NCH; c++) begin
        prx_q[c] <= cm_x[c] * px_q;
        pry_q[c] <= cm_y[c] * py_q;
        prz_q[c] <= cm_z[c] * pz_q;
        dz_q[c]  <= cm_z[c] * hh_s;
        dx_q[c]  <= cm_x[c] * rad_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NCH; c++) begin
        base_q[c] <= prx_q[c] + pry_q[c] + prz_q[c] + t_ext[c];
        dz2_q[c]  <= dz_q[c];
        dx2_q[c]  <= dx_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NCH; c++) begin
        pv_q[PT_CENTRE][c] <= base_q[c];
        pv_q[PT_TOP][c]    <= base_q[c] + dz2_q[c];
        pv_q[PT_BOTTOM][c] <= base_q[c] - dz2_q[c];
        pv_q[PT_LEFT][c]   <= base_q[c] - dx2_q[c];
        pv_q[PT_RIGHT][c]  <= base_q[c] + dx2_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NPT; k++) begin
        a_q[k]    <= pv_q[k][CH_X] + pv_q[k][CH_W];
        b_q[k]    <= pv_q[k][CH_W] - pv_q[k][CH_Y];
        cw4_q[k]  <= pv_q[k][CH_W];
        bad4_q[k] <= (pv_q[k][CH_W] <= thr);
      end
    end
  end

  // The wide factor is split in two halves so that each product stays narrow.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NPT; k++) begin
        phx_q[k]  <= $signed(a_q[k][A_W-1:LO_W]) * kx_s;
        plx_q[k]  <= a_q[k][LO_W-1:0] * kx;
        phy_q[k]  <= $signed(b_q[k][A_W-1:LO_W]) * ky_s;
        ply_q[k]  <= b_q[k][LO_W-1:0] * ky;
        cw5_q[k]  <= cw4_q[k];
        bad5_q[k] <= bad4_q[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NPT; k++) begin
      hx_e[k] = phx_q[k];
      hy_e[k] = phy_q[k];
      lx_e[k] = {{(NUM_W-PL_W){1'b0}}, plx_q[k]};
      ly_e[k] = {{(NUM_W-PL_W){1'b0}}, ply_q[k]};
      w_e[k]  = cw5_q[k];
      pt_d[k].num_x = (hx_e[k] <<< LO_W) + lx_e[k] + w_e[k];
      pt_d[k].num_y = (hy_e[k] <<< LO_W) + ly_e[k] + w_e[k];
      pt_d[k].den   = {cw5_q[k], 1'b0};
      pt_d[k].bad   = bad5_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q <= pt_d;
    end
  end

  assign pt_o = pt_q;

endmodule

### hw/rtl/psb_div.sv
// ----------------------------------------------------------------------------
// psb_div: pipelined floor division with range check
// Checks that the quotient fits the screen range, biases it to unsigned and
// resolves one quotient bit per stage by restoring subtraction.
// ----------------------------------------------------------------------------
module psb_div import psb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic                    ok_i,
  output psb_quo_t                quo_o
);

  localparam int NST  = SCR_W + 1;
  localparam int TW   = DIV_W + 1;
  localparam int PADW = DIV_W - DEN_W - SCR_W + 1;

  logic signed [DIV_W-1:0] num_e, bias, lo_e, hi_e;
  logic [DIV_W-1:0]        rem_q [SCR_W];
  logic [DEN_W-1:0]        dv_q [SCR_W];
  logic [SCR_W-1:0]        quo_q [NST];
  logic                    ok_q [NST];
  logic [TW-1:0]           trial [SCR_W];
  logic [SCR_W-1:0]        qn [SCR_W];

  // Adding den * 2^(SCR_W-1) turns the signed floor quotient into an unsigned one.
  always_comb begin
    num_e = num_i;
    bias  = {{PADW{1'b0}}, den_i, {(SCR_W-1){1'b0}}};
    lo_e  = num_e + bias;
    hi_e  = num_e - bias;
  end

  always_comb begin
    for (int j = 1; j <= SCR_W; j++) begin
      trial[j-1] = {1'b0, rem_q[j-1]} - (TW'(dv_q[j-1]) << (SCR_W - j));
      qn[j-1]    = quo_q[j-1] |
                   ({{(SCR_W-1){1'b0}}, ~trial[j-1][DIV_W]} << (SCR_W - j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= lo_e;
      dv_q[0]  <= den_i;
      quo_q[0] <= '0;
      ok_q[0]  <= ok_i & ~lo_e[DIV_W-1] & hi_e[DIV_W-1];
      for (int j = 1; j <= SCR_W; j++) begin
        quo_q[j] <= qn[j-1];
        ok_q[j]  <= ok_q[j-1];
      end
      for (int j = 1; j < SCR_W; j++) begin
        rem_q[j] <= trial[j-1][DIV_W] ? rem_q[j-1] : trial[j-1][DIV_W-1:0];
        dv_q[j]  <= dv_q[j-1];
      end
    end
  end

  assign quo_o.ok = ok_q[SCR_W];
  assign quo_o.q  = {~quo_q[SCR_W][SCR_W-1], quo_q[SCR_W][SCR_W-2:0]};

endmodule

### hw/rtl/psb_box.sv
// ----------------------------------------------------------------------------
// psb_box: box size and result assembly
// Takes the ten screen values, forms the absolute extents, clamps them to
// the viewport-dependent limits and blanks the result when any step failed.
// ----------------------------------------------------------------------------
module psb_box import psb_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  psb_quo_t [NPT-1:0]  quo_x_i,
  input  psb_quo_t [NPT-1:0]  quo_y_i,
  input  logic [VIEW_W-1:0]   view_w_i,
  input  logic [VIEW_W-1:0]   view_h_i,
  output psb_res_t            res_o
);

  localparam logic [SCR_W:0] LO_LIM = (SCR_W+1)'(1) << CFB;

  logic signed [SCR_W:0]   dw_s, dh_s;
  logic                    all_ok;
  logic                    ok_q;
  logic signed [SCR_W-1:0] cx_q, cy_q;
  logic [SCR_W:0]          dw_q, dh_q;
  logic [VIEW_W-1:0]       vmax;
  logic [SCR_W:0]          hi_lim;
  logic [SCR_W:0]          bw, bh;
  psb_res_t                res_d, res_q;

  always_comb begin
    all_ok = 1'b1;
    for (int k = 0; k < NPT; k++) begin
      all_ok = all_ok & quo_x_i[k].ok & quo_y_i[k].ok;
    end
    dw_s = quo_x_i[PT_RIGHT].q - quo_x_i[PT_LEFT].q;
    dh_s = quo_y_i[PT_BOTTOM].q - quo_y_i[PT_TOP].q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= all_ok;
      cx_q <= quo_x_i[PT_CENTRE].q;
      cy_q <= quo_y_i[PT_CENTRE].q;
      dw_q <= dw_s[SCR_W] ? -dw_s : dw_s;
      dh_q <= dh_s[SCR_W] ? -dh_s : dh_s;
    end
  end

  // The lower clamp is applied first so that a zero upper limit wins.
  always_comb begin
    vmax   = (view_w_i > view_h_i) ? view_w_i : view_h_i;
    hi_lim = (SCR_W+1)'(vmax) << (CFB + 1);
    bw     = (dw_q < LO_LIM) ? LO_LIM : dw_q;
    bw     = (bw > hi_lim) ? hi_lim : bw;
    bh     = (dh_q < LO_LIM) ? LO_LIM : dh_q;
    bh     = (bh > hi_lim) ? hi_lim : bh;
    res_d.valid_res = ok_q;
    res_d.center_x  = ok_q ? cx_q : '0;
    res_d.center_y  = ok_q ? cy_q : '0;
    res_d.box_w     = ok_q ? bw[BOX_W-1:0] : '0;
    res_d.box_h     = ok_q ? bh[BOX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
